[rtl/core/mts_pkg.sv]
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants for the merkle sha-256 engine
// Holds the transaction structs, operation and status codes, the sha-256
// round constant table and the initial hash value.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int unsigned NumBlocks  = 1024;
   localparam int unsigned TreeNodes  = 2 * NumBlocks - 1;
   localparam int unsigned BlkW       = 10;
   localparam int unsigned NodeW      = 11;

   // operation codes
   localparam logic [2:0] OP_CHECK  = 3'd0;
   localparam logic [2:0] OP_UPDATE = 3'd1;
   localparam logic [2:0] OP_LOAD   = 3'd2;
   localparam logic [2:0] OP_READ   = 3'd3;
   localparam logic [2:0] OP_VERIFY = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_MISMATCH = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;

   typedef struct packed {
      logic [2:0]        operation;
      logic [BlkW-1:0]   block_index;
      logic [NodeW-1:0]  node_index;
      logic [63:0]       digest_word_0;
      logic [63:0]       digest_word_1;
      logic [63:0]       digest_word_2;
      logic [63:0]       digest_word_3;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [NodeW-1:0]  bad_node;
      logic [63:0]       result_word_0;
      logic [63:0]       result_word_1;
      logic [63:0]       result_word_2;
      logic [63:0]       result_word_3;
   } rsp_type;

   // control handshake reported by hash unit to sequencer
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } hash_ctl_type;

   localparam logic [255:0] SHA_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] sha_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

endpackage

[rtl/core/mts_hash_unit.sv]
// ----------------------------------------------------------------------------
// mts_hash_unit: sha-256 of a 64-byte left/right digest pair
// One round per cycle; two compressions (message block, then padding block)
// give a 32-byte digest.
// ----------------------------------------------------------------------------
module mts_hash_unit import mts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [511:0] msg,
   output hash_ctl_type ctl,
   output logic [255:0] digest
);

   typedef enum logic [3:0] {
      H_IDLE  = 4'b0001,
      H_ROUND = 4'b0010,
      H_ADD   = 4'b0100,
      H_DONE  = 4'b1000
   } hstate_type;

   hstate_type    state_ff, state_in;
   logic [5:0]    round_ff, round_in;
   logic          second_ff, second_in;
   logic [511:0]  w_ff, w_in;
   logic [255:0]  s_ff, s_in;
   logic [255:0]  h_ff, h_in;

   logic [31:0] a, b, c, d, e, f, g, h, wi, t1, t2, e0, e1, ch, mj;
   logic [31:0] w1, w14, w9, w0, s0w, s1w, wnew;

   // round datapath
   always_comb begin
      {a, b, c, d, e, f, g, h} = s_ff;
      wi  = w_ff[511:480];
      e1  = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
      ch  = (e & f) ^ (~e & g);
      t1  = h + e1 + ch + sha_k(round_ff) + wi;
      e0  = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
      mj  = (a & b) ^ (a & c) ^ (b & c);
      t2  = e0 + mj;
      // message schedule as a 16-word shift window
      w0  = w_ff[511:480];
      w1  = w_ff[479:448];
      w9  = w_ff[223:192];
      w14 = w_ff[63:32];
      s0w = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
      s1w = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
      wnew = w0 + s0w + w9 + s1w;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      round_in  = round_ff;
      second_in = second_ff;
      w_in      = w_ff;
      s_in      = s_ff;
      h_in      = h_ff;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               w_in      = msg;
               s_in      = SHA_IV;
               h_in      = SHA_IV;
               round_in  = '0;
               second_in = 1'b0;
               state_in  = H_ROUND;
            end
         end
         H_ROUND: begin
            s_in = {t1 + t2, a, b, c, d + t1, e, f, g};
            w_in = {w_ff[479:0], wnew};
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) state_in = H_ADD;
         end
         H_ADD: begin
            for (int i = 0; i < 8; i++) begin
               h_in[i*32 +: 32] = h_ff[i*32 +: 32] + s_ff[i*32 +: 32];
            end
            if (second_ff) begin
               state_in = H_DONE;
            end else begin
               second_in = 1'b1;
               s_in      = h_in;
               w_in      = {32'h80000000, 448'd0, 32'd512};
               state_in  = H_ROUND;
            end
         end
         H_DONE:  state_in = H_IDLE;
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= H_IDLE;
         round_ff  <= '0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         round_ff  <= round_in;
         second_ff <= second_in;
      end
      w_ff <= w_in;
      s_ff <= s_in;
      h_ff <= h_in;
   end

   assign ctl.start = start;
   assign ctl.busy  = (state_ff != H_IDLE);
   assign ctl.done  = (state_ff == H_DONE);
   assign digest    = h_ff;

   a_done_after_add: assert property (@(posedge clock) disable iff (reset)
      ctl.done |-> $past(state_ff == H_ADD) && second_ff)
      else $error("hash done without final add");
   a_round_wraps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == H_ROUND && round_ff == 6'd63) |=> state_ff == H_ADD)
      else $error("round counter did not end compression");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == H_IDLE) |=> state_ff == H_ROUND && round_ff == 6'd0)
      else $error("start not taken");

endmodule

[rtl/core/merkle_tree_sha256_engine_core.sv]
// ----------------------------------------------------------------------------
// merkle_tree_sha256_engine_core: sha-256 merkle tree keeper
// Stores 2047 node digests and loads, updates, reads, checks or verifies them.
// ----------------------------------------------------------------------------
// Usage: a request transaction (req_valid/req_ready, req_data) carries one
// operation; exactly one response transaction (rsp_valid/rsp_ready,
// rsp_data) follows. req_ready is high only while the engine is idle, so one
// transaction is worked at a time.
// Load writes the node's four words; read and check fetch them (node store read is
// registered, one 64-bit word per cycle); out-of-range and unknown operations
// go straight to the response state. Update writes the leaf and then
// rehashes 10 levels; each level reads 8 words and runs one hash of two
// compressions at one round per cycle. Verify hashes each internal node in
// order up to the first mismatch, at most 1023 nodes. All hashing goes
// through the single hash unit.
// Reset clears the sequencer and response valid; the node store has no reset
// and must be loaded or updated before it is read.
// When the receiver stalls, the response is held in its register and
// req_ready stays low until it is taken.
// ----------------------------------------------------------------------------
module merkle_tree_sha256_engine_core import mts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int unsigned Words = TreeNodes * 4;
   localparam int unsigned AddrW = $clog2(Words);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_WLEAF  = 9'b000000010,
      S_RD     = 9'b000000100,
      S_RDWAIT = 9'b000001000,
      S_HASH   = 9'b000010000,
      S_HWAIT  = 9'b000100000,
      S_POST   = 9'b001000000,
      S_RESP   = 9'b010000000,
      S_CMP    = 9'b100000000
   } state_type;

   state_type      state_ff, state_in;
   req_type        req_ff, req_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [NodeW-1:0] node_ff, node_in;
   logic [3:0]     cnt_ff, cnt_in;
   logic [511:0]   buf_ff, buf_in;
   logic [255:0]   cur_ff, cur_in;
   logic [AddrW-1:0] rd_addr, wr_addr;
   logic           rd_en, wr_en;
   logic [63:0]    wr_data, rd_data_ff;
   logic           rd_pend_ff;
   logic [2:0]     rd_slot_ff;
   logic           hash_start;
   hash_ctl_type   hctl;
   logic [255:0]   hdigest;

   logic [63:0] mem [Words];

   // node store, one word per cycle each way
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   mts_hash_unit u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .msg    (buf_ff),
      .ctl    (hctl),
      .digest (hdigest)
   );

   logic is_upd, is_ver;
   logic [NodeW:0] child;
   assign is_upd = (req_ff.operation == OP_UPDATE);
   assign is_ver = (req_ff.operation == OP_VERIFY);
   // read list: verify/update read 8 child words, first child is 2n+1
   assign child = {node_ff, 1'b0} + (NodeW + 1)'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      node_in      = node_ff;
      cnt_in       = cnt_ff;
      buf_in       = buf_ff;
      cur_in       = cur_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      hash_start   = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      // capture read data in the cycle after issue
      if (rd_pend_ff) begin
         if (state_ff == S_POST || state_ff == S_CMP || !(is_upd || is_ver))
            cur_in[(3 - rd_slot_ff[1:0])*64 +: 64] = rd_data_ff;
         else
            buf_in[(7 - rd_slot_ff)*64 +: 64] = rd_data_ff;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               req_in = req_data;
               rsp_in = '0;
               cnt_in = '0;
               node_in = '0;
               cur_in = '0;
               case (req_data.operation)
                  OP_CHECK, OP_UPDATE: begin
                     if (32'(req_data.block_index) >= NumBlocks) begin
                        rsp_in.status = ST_RANGE;
                        state_in = S_RESP;
                     end else begin
                        node_in = NodeW'(32'(req_data.block_index) + NumBlocks - 1);
                        state_in = (req_data.operation == OP_UPDATE) ? S_WLEAF : S_RD;
                     end
                  end
                  OP_LOAD, OP_READ: begin
                     if (32'(req_data.node_index) >= TreeNodes) begin
                        rsp_in.status = ST_RANGE;
                        state_in = S_RESP;
                     end else begin
                        node_in = req_data.node_index;
                        state_in = (req_data.operation == OP_LOAD) ? S_WLEAF : S_RD;
                     end
                  end
                  OP_VERIFY: state_in = S_RD;
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_WLEAF: begin
            // write the incoming digest, one word per cycle
            wr_en   = 1'b1;
            wr_addr = AddrW'({node_ff, cnt_ff[1:0]});
            case (cnt_ff[1:0])
               2'd0:    wr_data = req_ff.digest_word_0;
               2'd1:    wr_data = req_ff.digest_word_1;
               2'd2:    wr_data = req_ff.digest_word_2;
               default: wr_data = req_ff.digest_word_3;
            endcase
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin
               cnt_in = '0;
               if (is_upd && node_ff != '0) begin
                  node_in  = NodeW'((node_ff - NodeW'(1)) >> 1);
                  state_in = S_RD;
               end else if (is_upd) begin
                  state_in = S_RD;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_RD: begin
            // issue reads: children (8 words) for hashing, else the node itself
            rd_en = 1'b1;
            if (is_upd || is_ver)
               rd_addr = AddrW'({child, 2'b00}) + AddrW'(cnt_ff);
            else
               rd_addr = AddrW'({node_ff, cnt_ff[1:0]});
            cnt_in = cnt_ff + 4'd1;
            if ((is_upd || is_ver) ? cnt_ff == 4'd7 : cnt_ff == 4'd3) begin
               cnt_in = '0;
               state_in = S_RDWAIT;
            end
         end
         S_RDWAIT: begin
            if (is_upd || is_ver) begin
               state_in = S_HASH;
            end else if (req_ff.operation == OP_READ) begin
               rsp_in.result_word_0 = cur_in[255:192];
               rsp_in.result_word_1 = cur_in[191:128];
               rsp_in.result_word_2 = cur_in[127:64];
               rsp_in.result_word_3 = cur_in[63:0];
               state_in = S_RESP;
            end else begin
               if (cur_in != {req_ff.digest_word_0, req_ff.digest_word_1,
                              req_ff.digest_word_2, req_ff.digest_word_3})
                  rsp_in.status = ST_MISMATCH;
               state_in = S_RESP;
            end
         end
         S_HASH: begin
            hash_start = 1'b1;
            state_in = S_HWAIT;
         end
         S_HWAIT: begin
            if (hctl.done) begin
               cur_in = hdigest;
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (is_upd) begin
               // store the new node digest
               wr_en   = 1'b1;
               wr_addr = AddrW'({node_ff, cnt_ff[1:0]});
               wr_data = cur_ff[(3 - cnt_ff[1:0])*64 +: 64];
               cnt_in  = cnt_ff + 4'd1;
               if (cnt_ff == 4'd3) begin
                  cnt_in = '0;
                  if (node_ff == '0) begin
                     rsp_in.result_word_0 = cur_ff[255:192];
                     rsp_in.result_word_1 = cur_ff[191:128];
                     rsp_in.result_word_2 = cur_ff[127:64];
                     rsp_in.result_word_3 = cur_ff[63:0];
                     state_in = S_RESP;
                  end else begin
                     node_in  = NodeW'((node_ff - NodeW'(1)) >> 1);
                     state_in = S_RD;
                  end
               end
            end else begin
               // verify: fetch stored digest of this node
               if (cnt_ff == 4'd0) buf_in[511:256] = cur_ff;
               rd_en   = 1'b1;
               rd_addr = AddrW'({node_ff, cnt_ff[1:0]});
               cnt_in  = cnt_ff + 4'd1;
               if (cnt_ff == 4'd3) begin
                  cnt_in = '0;
                  state_in = S_CMP;
               end
            end
         end
         S_CMP: begin
            // last stored word lands this cycle
            if (cur_in != buf_ff[511:256]) begin
               rsp_in.status   = ST_MISMATCH;
               rsp_in.bad_node = node_ff;
               state_in = S_RESP;
            end else if (32'(node_ff) + 2 >= NumBlocks) begin
               state_in = S_RESP;
            end else begin
               node_in  = node_ff + NodeW'(1);
               state_in = S_RD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // verify keeps hash result in buf top half while stored node fills cur
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_en;
      end
      rd_slot_ff <= cnt_ff[2:0];
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      node_ff <= node_in;
      cnt_ff  <= cnt_in;
      buf_ff  <= buf_in;
      cur_ff  <= cur_in;
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("response not raised");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_WLEAF || state_ff == S_POST))
      else $error("store write outside write states");
   a_hash_idle_start: assert property (@(posedge clock) disable iff (reset)
      hash_start |-> !hctl.busy)
      else $error("hash started while busy");

endmodule

[dv/merkle_tree_sha256_engine_core_test.sv]
// ----------------------------------------------------------------------------
// merkle_tree_sha256_engine_core_test: self-checking bench for the merkle core
// Fills the whole tree with a consistent set of node hashes and then runs
// directed and random check, update, load, read and verify transactions
// against a sha-256 tree predictor, with random stalls on both channels.
// ----------------------------------------------------------------------------
module merkle_tree_sha256_engine_core_test;
   import mts_pkg::*;

   localparam int unsigned CycleLimit = 4000000;
   localparam int unsigned RandomItems = 420;
   localparam int unsigned LeafBase = NumBlocks - 1;

   localparam bit [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam bit [255:0] StartHash = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   // tree predictor and store of pending responses
   class merkle_scoreboard;
      bit [255:0] tree [TreeNodes];
      rsp_type due [$];
      int errors;

      function bit [31:0] rotr(bit [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      // one sha-256 compression of a 512-bit block into the chaining value
      function bit [255:0] compress(bit [255:0] hv, bit [511:0] msg);
         bit [31:0] w [64];
         bit [31:0] s [8];
         bit [31:0] s0, s1, t1, t2;
         for (int i = 0; i < 16; i++) w[i] = msg[511 - 32*i -: 32];
         for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
         end
         for (int i = 0; i < 8; i++) s[i] = hv[255 - 32*i -: 32];
         for (int i = 0; i < 64; i++) begin
            t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
                 + ((s[4] & s[5]) ^ (~s[4] & s[6])) + RoundK[i] + w[i];
            t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
                 + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
            s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
            s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) hv[255 - 32*i -: 32] += s[i];
         return hv;
      endfunction

      // digest of a node from its two children, padding block included
      function bit [255:0] node_hash(int n);
         bit [255:0] hv;
         hv = compress(StartHash, {tree[2*n+1], tree[2*n+2]});
         return compress(hv, {32'h80000000, 448'd0, 32'd512});
      endfunction

      // first internal node whose digest disagrees with its children, or -1
      function int first_bad();
         for (int i = 0; i < NumBlocks - 1; i++)
            if (node_hash(i) != tree[i]) return i;
         return -1;
      endfunction

      function void note_request(req_type r);
         rsp_type want;
         bit [255:0] dig;
         int n, bad;
         want = '0;
         dig = {r.digest_word_0, r.digest_word_1, r.digest_word_2, r.digest_word_3};
         case (r.operation)
            OP_CHECK: begin
               if (tree[LeafBase + r.block_index] != dig) want.status = ST_MISMATCH;
            end
            OP_UPDATE: begin
               n = LeafBase + r.block_index;
               tree[n] = dig;
               while (n > 0) begin
                  n = (n - 1) / 2;
                  tree[n] = node_hash(n);
               end
               {want.result_word_0, want.result_word_1, want.result_word_2,
                want.result_word_3} = tree[0];
            end
            OP_LOAD, OP_READ: begin
               if (r.node_index >= TreeNodes) want.status = ST_RANGE;
               else if (r.operation == OP_LOAD) tree[r.node_index] = dig;
               else {want.result_word_0, want.result_word_1, want.result_word_2,
                     want.result_word_3} = tree[r.node_index];
            end
            OP_VERIFY: begin
               bad = first_bad();
               if (bad >= 0) begin
                  want.status = ST_MISMATCH;
                  want.bad_node = bad[NodeW-1:0];
               end
            end
            default: ;
         endcase
         due.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (due.size() == 0) begin
            $error("response transaction with nothing pending");
            errors++;
            return;
         end
         want = due.pop_front();
         if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status); errors++;
         end
         if (got.bad_node !== want.bad_node) begin
            $error("bad_node expected %0d got %0d", want.bad_node, got.bad_node); errors++;
         end
         if (got.result_word_0 !== want.result_word_0) begin
            $error("result_word_0 expected %h got %h", want.result_word_0,
                   got.result_word_0); errors++;
         end
         if (got.result_word_1 !== want.result_word_1) begin
            $error("result_word_1 expected %h got %h", want.result_word_1,
                   got.result_word_1); errors++;
         end
         if (got.result_word_2 !== want.result_word_2) begin
            $error("result_word_2 expected %h got %h", want.result_word_2,
                   got.result_word_2); errors++;
         end
         if (got.result_word_3 !== want.result_word_3) begin
            $error("result_word_3 expected %h got %h", want.result_word_3,
                   got.result_word_3); errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   merkle_scoreboard sb = new();
   bit quiet = 1'b0;
   bit sender_calm = 1'b0;
   int rsp_hold = 0;
   int unsigned cycles = 0;

   merkle_tree_sha256_engine_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watch both channels and feed the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // receiver stalls in short bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_hold = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("FAIL merkle_tree_sha256_engine_core");
         $finish;
      end
   end

   function automatic bit [255:0] rand_digest();
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom};
   endfunction

   // drive one request transaction and wait for it to be taken
   task automatic send(logic [2:0] op, int unsigned blk, int unsigned node,
                       bit [255:0] dig);
      req_type r;
      r.operation = op;
      r.block_index = blk[BlkW-1:0];
      r.node_index = node[NodeW-1:0];
      {r.digest_word_0, r.digest_word_1, r.digest_word_2, r.digest_word_3} = dig;
      if (!quiet && !sender_calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.due.size() != 0) @(posedge clock);
   endtask

   initial begin
      bit [255:0] fill [TreeNodes];
      bit [255:0] dig;
      int unsigned op_pick, blk, node;
      int bad;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // nothing here touches the node store
      send(OP_LOAD, 0, TreeNodes, rand_digest());
      send(OP_READ, 0, 11'h7ff, '1);
      send(3'd5, 0, 0, '0);
      send(3'd6, 1023, 2047, '1);
      send(3'd7, $urandom_range(0, 1023), $urandom_range(0, 2047), rand_digest());

      // fill the whole tree with consistent hashes, leaves at the extremes too
      for (int i = 0; i < NumBlocks; i++) sb.tree[LeafBase + i] = rand_digest();
      sb.tree[LeafBase] = '0;
      sb.tree[TreeNodes - 1] = '1;
      for (int i = NumBlocks - 2; i >= 0; i--) sb.tree[i] = sb.node_hash(i);
      fill = sb.tree;
      for (int i = 0; i < TreeNodes; i++) send(OP_LOAD, 0, i, fill[i]);

      // pause until the fill has fully drained
      wait_drained();

      // directed transactions
      send(OP_VERIFY, 0, 0, '0);
      send(OP_CHECK, 0, 0, '0);
      send(OP_CHECK, 1023, 0, '0);
      send(OP_CHECK, 1023, 0, '1);
      send(OP_READ, 0, 0, '0);
      send(OP_READ, 0, TreeNodes - 1, '0);
      send(OP_UPDATE, 0, 0, '1);
      send(OP_UPDATE, 1023, 2047, '0);
      send(OP_LOAD, 0, NumBlocks - 2, rand_digest());
      send(OP_VERIFY, 0, 0, '0);
      send(OP_UPDATE, 1023, 0, rand_digest());
      send(OP_LOAD, 0, 0, rand_digest());
      send(OP_VERIFY, 1023, 2047, '1);
      send(OP_UPDATE, 5, 0, rand_digest());
      send(OP_READ, 0, 0, '0);
      send(OP_READ, 0, TreeNodes, '0);

      // random mix, mostly well-formed tree traffic
      for (int k = 0; k < RandomItems; k++) begin
         if (k % 50 == 0) sender_calm = ($urandom_range(0, 3) == 0);
         if (k == RandomItems - 40) quiet = 1'b1;
         op_pick = $urandom_range(0, 99);
         blk = $urandom_range(0, NumBlocks - 1);
         node = $urandom_range(0, TreeNodes - 1);
         dig = rand_digest();
         if (op_pick < 25) begin
            send(OP_UPDATE, blk, node, dig);
         end else if (op_pick < 50) begin
            if ($urandom_range(0, 1)) dig = sb.tree[LeafBase + blk];
            send(OP_CHECK, blk, node, dig);
         end else if (op_pick < 70) begin
            send(OP_READ, blk, node, dig);
         end else if (op_pick < 80) begin
            send(OP_LOAD, blk, node, dig);
         end else if (op_pick < 86) begin
            send($urandom_range(0, 1) ? OP_LOAD : OP_READ, blk,
                 $urandom_range(TreeNodes, 2047), dig);
         end else if (op_pick < 89) begin
            send(3'($urandom_range(5, 7)), blk, node, dig);
         end else if (op_pick < 92) begin
            // keep verify short: break a node near the root first if needed
            bad = sb.first_bad();
            if (bad < 0 || bad > 255)
               send(OP_LOAD, blk, $urandom_range(0, 254), rand_digest());
            send(OP_VERIFY, blk, node, dig);
         end else begin
            // repair the root from a fresh leaf, then read it back
            send(OP_UPDATE, blk, node, dig);
            send(OP_READ, blk, 0, dig);
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.due.size() == 0)
         $display("PASS merkle_tree_sha256_engine_core");
      else
         $display("FAIL merkle_tree_sha256_engine_core");
      $finish;
   end

endmodule
